// ----- sv/pps_pkg.sv -----
package pps_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int PHASE_W     = FRAC_BITS + 1;
    localparam int SPAN_W      = PHASE_W + 1;
    localparam int SEG_W       = 5;
    localparam int IDX_W       = 4;
    localparam int SET_W       = 4;
    localparam int MAX_SPLITS  = 16;
    localparam int MAX_SETS    = 16;
    localparam int QUO_W       = FRAC_BITS;
    localparam int DIV_STEPS   = QUO_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT   = 2'd1;

    localparam logic CMD_PHASE = 1'b0;
    localparam logic CMD_SPLIT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [PHASE_W-1:0] phase;
        logic [IDX_W-1:0]   split_index;
        logic [PHASE_W-1:0] split_value;
    } pps_in_t;

    typedef struct packed {
        logic [PHASE_W-1:0] local_phase;
        logic [SEG_W-1:0]   segment;
        logic [SET_W-1:0]   param_set;
        logic               reload_params;
    } pps_out_t;

    // classified item between front and back
    typedef struct packed {
        logic               is_split;
        logic [PHASE_W-1:0] phase;
        logic [IDX_W-1:0]   slot;
        logic [PHASE_W-1:0] value;
    } pps_item_t;

    typedef struct packed {
        logic      valid;
        pps_item_t item;
    } pps_queue_t;

endpackage

// ----- sv/pps_front.sv -----
module pps_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pps_pkg::pps_in_t  s_payload,
    output pps_pkg::pps_queue_t q_out,
    input  logic              q_pop
);

    pps_pkg::pps_item_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic               push;
    logic               pop;
    pps_pkg::pps_item_t item_in;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_out.valid;

    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = entry_reg[rd_ptr_reg];

    always_comb begin
        item_in.is_split = (s_payload.cmd == pps_pkg::CMD_SPLIT);
        item_in.phase    = s_payload.phase;
        item_in.slot     = s_payload.split_index;
        item_in.value    = s_payload.split_value;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- sv/pps_back.sv -----
module pps_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pps_pkg::pps_queue_t             q_in,
    output logic                            q_pop,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pps_pkg::pps_out_t               m_payload
);

    localparam int PW = pps_pkg::PHASE_W;
    localparam int SW = pps_pkg::SPAN_W;
    localparam int GW = pps_pkg::SEG_W;
    localparam int XW = pps_pkg::IDX_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_BOUND  = 3'd2;
    localparam logic [2:0] ST_PREP   = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    localparam logic [GW-1:0] SPLITS_MAX = GW'(pps_pkg::MAX_SPLITS);
    localparam logic [GW-1:0] SETS_MAX   = GW'(pps_pkg::MAX_SETS);

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [PW-1:0]       table_reg [pps_pkg::MAX_SPLITS];
    logic [GW-1:0]       split_count_reg;
    logic [GW-1:0]       set_count_reg;
    logic [GW-1:0]       cur_seg_reg;
    logic [PW-1:0]       prev_phase_reg;
    logic [PW-1:0]       seg_low_reg;
    logic signed [SW-1:0] seg_span_reg;
    logic                force_reg;
    logic [GW-1:0]       seg_reg;
    logic [PW-1:0]       phase_reg;
    logic [PW-1:0]       hi_reg;
    logic                changed_reg;
    logic [GW-1:0]       mod_reg;
    logic [PW-1:0]       rem_reg;
    logic [PW-1:0]       den_reg;
    logic [pps_pkg::QUO_W-1:0] quo_reg;
    logic [PW-1:0]       lp_reg;
    logic                div_run_reg;
    logic [pps_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic                out_valid_reg;
    pps_pkg::pps_out_t   out_reg;

    logic [PW-1:0]       rd_cur;
    logic [PW-1:0]       rd_prev;
    logic [GW-1:0]       seg_dec;
    logic [GW-1:0]       seg_start;
    logic                search_go;
    logic                changed;
    logic [PW-1:0]       lo_new;
    logic signed [SW-1:0] num_s;
    logic [SW-1:0]       num_neg;
    logic [SW-1:0]       span_neg;
    logic [PW-1:0]       num_abs;
    logic [PW-1:0]       span_abs;
    logic [SW-1:0]       t1;
    logic [SW-1:0]       t2;
    logic                g1;
    logic                g2;
    logic [PW-1:0]       r1;
    logic [PW-1:0]       r2;
    logic                mod_done;
    logic                mod_step;
    logic                out_free;
    logic                pop;
    logic [GW-1:0]       cfg_sat;

    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    assign out_free = !out_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE);
    assign pop      = q_pop && q_in.valid;

    assign cfg_sat = (cfg_data > SPLITS_MAX) ? SPLITS_MAX : cfg_data;

    assign seg_dec = seg_reg - GW'(1);
    assign rd_cur  = table_reg[seg_reg[XW-1:0]];
    assign rd_prev = table_reg[seg_dec[XW-1:0]];

    assign seg_start = (q_in.item.phase < prev_phase_reg) ? '0 :
                       (cur_seg_reg > split_count_reg) ? split_count_reg : cur_seg_reg;

    assign search_go = (seg_reg < split_count_reg) && (phase_reg >= rd_cur);
    assign changed   = (seg_reg != cur_seg_reg) || force_reg;
    assign lo_new    = (seg_reg == '0) ? '0 : rd_prev;

    assign num_s    = $signed({1'b0, phase_reg}) - $signed({1'b0, seg_low_reg});
    assign num_neg  = -num_s;
    assign span_neg = -seg_span_reg;
    assign num_abs  = num_s[SW-1] ? num_neg[PW-1:0] : num_s[PW-1:0];
    assign span_abs = seg_span_reg[SW-1] ? span_neg[PW-1:0] : seg_span_reg[PW-1:0];

    // two restoring steps per cycle
    always_comb begin
        t1 = {rem_reg, 1'b0};
        g1 = (t1 >= {1'b0, den_reg});
        r1 = g1 ? PW'(t1 - {1'b0, den_reg}) : t1[PW-1:0];
        t2 = {r1, 1'b0};
        g2 = (t2 >= {1'b0, den_reg});
        r2 = g2 ? PW'(t2 - {1'b0, den_reg}) : t2[PW-1:0];
    end

    assign mod_done = (set_count_reg == '0) || (mod_reg < set_count_reg);
    assign mod_step = ((state_reg == ST_PREP) || (state_reg == ST_DIV)) && !mod_done;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop && !q_in.item.is_split) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!search_go) begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND: state_next = ST_PREP;
            ST_PREP:  state_next = ST_DIV;
            ST_DIV: begin
                if (!div_run_reg && mod_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop && q_in.item.is_split) begin
            table_reg[q_in.item.slot] <= q_in.item.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && pop) begin
            phase_reg <= q_in.item.phase;
        end
        if (state_reg == ST_SEARCH && !search_go) begin
            hi_reg <= (seg_reg >= split_count_reg) ? pps_pkg::PHASE_ONE : rd_cur;
        end
        if (state_reg == ST_PREP) begin
            if (seg_span_reg == '0) begin
                lp_reg <= pps_pkg::PHASE_ONE;
            end else if (num_s == '0 || num_s[SW-1] != seg_span_reg[SW-1]) begin
                lp_reg <= '0;
            end else if (num_abs >= span_abs) begin
                lp_reg <= pps_pkg::PHASE_ONE;
            end
            rem_reg     <= num_abs;
            den_reg     <= span_abs;
            quo_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (state_reg == ST_DIV && div_run_reg) begin
            rem_reg     <= r2;
            quo_reg     <= {quo_reg[pps_pkg::QUO_W-3:0], g1, g2};
            div_cnt_reg <= div_cnt_reg + pps_pkg::DIV_CNT_W'(1);
            if (div_cnt_reg == pps_pkg::DIV_CNT_W'(pps_pkg::DIV_STEPS - 1)) begin
                lp_reg <= {1'b0, quo_reg[pps_pkg::QUO_W-3:0], g1, g2};
            end
        end
        if (state_reg == ST_BOUND) begin
            mod_reg <= seg_reg;
        end else if (mod_step) begin
            mod_reg <= mod_reg - set_count_reg;
        end
        if (state_reg == ST_OUT && out_free) begin
            out_reg.local_phase   <= lp_reg;
            out_reg.segment       <= seg_reg;
            out_reg.param_set     <= (set_count_reg == '0) ? '0 : mod_reg[pps_pkg::SET_W-1:0];
            out_reg.reload_params <= changed_reg && (set_count_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            split_count_reg <= '0;
            set_count_reg   <= '0;
            cur_seg_reg     <= '0;
            prev_phase_reg  <= pps_pkg::PHASE_ONE;
            seg_low_reg     <= '0;
            seg_span_reg    <= SW'(pps_pkg::PHASE_ONE);
            force_reg       <= 1'b1;
            seg_reg         <= '0;
            changed_reg     <= 1'b0;
            div_run_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        if (q_in.item.is_split) begin
                            force_reg <= 1'b1;
                        end else begin
                            seg_reg <= seg_start;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (search_go) begin
                        seg_reg <= seg_reg + GW'(1);
                    end
                end
                ST_BOUND: begin
                    changed_reg <= changed;
                    if (changed) begin
                        seg_low_reg  <= lo_new;
                        seg_span_reg <= $signed({1'b0, hi_reg}) - $signed({1'b0, lo_new});
                    end
                end
                ST_PREP: begin
                    div_run_reg <= (seg_span_reg != '0) && (num_s != '0) &&
                                   (num_s[SW-1] == seg_span_reg[SW-1]) &&
                                   (num_abs < span_abs);
                end
                ST_DIV: begin
                    if (div_run_reg &&
                        div_cnt_reg == pps_pkg::DIV_CNT_W'(pps_pkg::DIV_STEPS - 1)) begin
                        div_run_reg <= 1'b0;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        cur_seg_reg    <= seg_reg;
                        prev_phase_reg <= phase_reg;
                        force_reg      <= 1'b0;
                    end
                end
                default: begin
                end
            endcase

            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pps_pkg::CFG_SPLIT_COUNT: begin
                        split_count_reg <= cfg_sat;
                        force_reg       <= 1'b1;
                    end
                    pps_pkg::CFG_SET_COUNT: begin
                        set_count_reg <= (cfg_data > SETS_MAX) ? SETS_MAX : cfg_data;
                        force_reg     <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- sv/piecewise_phase_segmenter_unit.sv -----
// Flow: a phase beat waits in the input queue, then the back end steps through IDLE, SEARCH
// (one table compare per cycle), BOUND, PREP, DIV (radix-4 divider running while the segment
// modulo finishes, one subtraction per cycle) and OUT into the output register on m_.
// A split-write beat is written into the split table when popped and gives no result.
// The back end works on one phase beat at a time and takes no new beat until it is done;
// a 2-deep input queue and the output register decouple both channels.
// Reset (aresetn low, synchronous): queue and result cleared, counts zero, reload forced.
module piecewise_phase_segmenter_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pps_pkg::pps_in_t                s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pps_pkg::pps_out_t               m_payload,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pps_pkg::pps_queue_t queue;
    logic                q_pop;

    pps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_out     (queue),
        .q_pop     (q_pop)
    );

    pps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_in      (queue),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ----- sv/pps_checker.sv -----
module pps_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input pps_pkg::pps_in_t                s_payload,
    input logic                            m_valid,
    input logic                            m_ready,
    input pps_pkg::pps_out_t               m_payload,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [pps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [pps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [pps_pkg::CFG_DATA_W-1:0] SETS_MAX =
        pps_pkg::CFG_DATA_W'(pps_pkg::MAX_SETS);

    logic [pps_pkg::CFG_DATA_W-1:0] sets_reg;

    // shadow of the parameter set count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sets_reg <= '0;
        end else if (cfg_valid && cfg_ready && cfg_index == pps_pkg::CFG_SET_COUNT) begin
            sets_reg <= (cfg_data > SETS_MAX) ? SETS_MAX : cfg_data;
        end
    end

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_payload))
        else $error("waiting input beat changed");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.local_phase <= pps_pkg::PHASE_ONE &&
                    m_payload.segment <= pps_pkg::SEG_W'(pps_pkg::MAX_SPLITS))
        else $error("result out of range");

    a_param_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (sets_reg == '0) ?
            (m_payload.param_set == '0 && !m_payload.reload_params) :
            ({1'b0, m_payload.param_set} < sets_reg))
        else $error("parameter set inconsistent with set count");

endmodule

bind piecewise_phase_segmenter_unit pps_checker u_pps_checker (.*);

// ----- verif/piecewise_phase_segmenter_unit_tb.sv -----
`timescale 1ns / 100ps

module piecewise_phase_segmenter_unit_tb;

    localparam logic [pps_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [pps_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_MAX     = 131071;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    pps_pkg::pps_in_t               s_payload = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    pps_pkg::pps_out_t              m_payload;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pps_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // segmenter shadow state
    logic [pps_pkg::PHASE_W-1:0] split_shadow [pps_pkg::MAX_SPLITS];
    int                          seg_now     = 0;
    logic [pps_pkg::PHASE_W-1:0] prior_phase = pps_pkg::PHASE_ONE;
    logic [pps_pkg::PHASE_W-1:0] span_lo     = '0;
    int                          span_len    = int'(pps_pkg::PHASE_ONE);
    bit                          reload_due  = 1'b1;
    int                          n_splits    = 0;
    int                          n_sets      = 0;

    pps_pkg::pps_out_t expected_segments [$];
    int       mismatch_cnt = 0;
    int       stall_cycles = 0;
    bit       src_idle_on  = 1'b1;
    bit       snk_idle_on  = 1'b1;
    logic     hold_on      = 1'b0;
    int       snk_gap      = 0;

    piecewise_phase_segmenter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void apply_reg(input logic [pps_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [pps_pkg::CFG_DATA_W-1:0] val);
        if (idx == pps_pkg::CFG_SPLIT_COUNT) begin
            n_splits   = (val > pps_pkg::MAX_SPLITS) ? pps_pkg::MAX_SPLITS : int'(val);
            reload_due = 1'b1;
        end else if (idx == pps_pkg::CFG_SET_COUNT) begin
            n_sets     = (val > pps_pkg::MAX_SETS) ? pps_pkg::MAX_SETS : int'(val);
            reload_due = 1'b1;
        end
    endfunction

    function automatic void track_beat(input pps_pkg::pps_in_t b);
        int                seg;
        int                hi;
        bit                moved;
        longint            num;
        longint            den;
        longint            q;
        pps_pkg::pps_out_t r;
        if (b.cmd == pps_pkg::CMD_SPLIT) begin
            split_shadow[b.split_index] = b.split_value;
            reload_due = 1'b1;
            return;
        end
        seg = (seg_now > n_splits) ? n_splits : seg_now;
        if (b.phase < prior_phase) seg = 0;
        while (seg < n_splits && b.phase >= split_shadow[seg]) seg++;
        moved = (seg != seg_now) || reload_due;
        if (moved) begin
            span_lo  = (seg == 0) ? '0 : split_shadow[seg-1];
            hi       = (seg >= n_splits) ? int'(pps_pkg::PHASE_ONE) : int'(split_shadow[seg]);
            span_len = hi - int'(span_lo);
        end
        num = longint'(b.phase) - longint'(span_lo);
        den = span_len;
        if (den == 0) begin
            q = longint'(pps_pkg::PHASE_ONE);
        end else if (num == 0 || ((num < 0) != (den < 0))) begin
            q = 0;
        end else begin
            if (num < 0) num = -num;
            if (den < 0) den = -den;
            q = (num << pps_pkg::FRAC_BITS) / den;
            if (q > longint'(pps_pkg::PHASE_ONE)) q = longint'(pps_pkg::PHASE_ONE);
        end
        r.local_phase   = q[pps_pkg::PHASE_W-1:0];
        r.segment       = seg[pps_pkg::SEG_W-1:0];
        r.param_set     = (n_sets != 0) ? pps_pkg::SET_W'(seg % n_sets) : '0;
        r.reload_params = moved && (n_sets != 0);
        prior_phase = b.phase;
        seg_now     = seg;
        reload_due  = 1'b0;
        expected_segments.push_back(r);
    endfunction

    task automatic check_result(input pps_pkg::pps_out_t got);
        pps_pkg::pps_out_t want;
        if (expected_segments.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing pending", got));
            return;
        end
        want = expected_segments.pop_front();
        if (got.local_phase !== want.local_phase)
            report_mismatch($sformatf("local_phase %0d, want %0d",
                                      got.local_phase, want.local_phase));
        if (got.segment !== want.segment)
            report_mismatch($sformatf("segment %0d, want %0d", got.segment, want.segment));
        if (got.param_set !== want.param_set)
            report_mismatch($sformatf("param_set %0d, want %0d",
                                      got.param_set, want.param_set));
        if (got.reload_params !== want.reload_params)
            report_mismatch($sformatf("reload_params %0b, want %0b",
                                      got.reload_params, want.reload_params));
    endtask

    // inputs only move at rising edges, so the falling edge sees settled handshakes
    always @(negedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) track_beat(s_payload);
            if (m_valid && m_ready) check_result(m_payload);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("piecewise_phase_segmenter_unit_tb NOT OK");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_gap <= 0;
        end else if (hold_on) begin
            m_ready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            m_ready <= 1'b0;
        end else if (snk_idle_on && $urandom_range(0, 9) == 0) begin
            snk_gap <= $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic pps_pkg::pps_in_t phase_beat(input int ph);
        pps_pkg::pps_in_t b;
        b.cmd         = pps_pkg::CMD_PHASE;
        b.phase       = pps_pkg::PHASE_W'(ph);
        b.split_index = pps_pkg::IDX_W'($urandom);
        b.split_value = pps_pkg::PHASE_W'($urandom);
        return b;
    endfunction

    function automatic pps_pkg::pps_in_t split_beat(input int slot, input int val);
        pps_pkg::pps_in_t b;
        b.cmd         = pps_pkg::CMD_SPLIT;
        b.phase       = pps_pkg::PHASE_W'($urandom);
        b.split_index = pps_pkg::IDX_W'(slot);
        b.split_value = pps_pkg::PHASE_W'(val);
        return b;
    endfunction

    // returns on the falling edge before the accepting rising edge
    task automatic send_beat(input pps_pkg::pps_in_t b);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
        @(posedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_payload <= b;
        s_valid   <= 1'b1;
        do @(negedge aclk); while (!s_ready);
    endtask

    task automatic settle();
        @(posedge aclk);
        s_valid <= 1'b0;
        while (expected_segments.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [pps_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= pps_pkg::CFG_DATA_W'(val);
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_beat(phase_beat(0));
        send_beat(phase_beat(int'(pps_pkg::PHASE_ONE)));
        send_beat(phase_beat(PHASE_MAX));
        settle();
    endtask

    // duplicate split and a last split at 1.0 give zero-span segments
    task automatic test_segment_walk();
        send_beat(split_beat(0, 16384));
        send_beat(split_beat(1, 32768));
        send_beat(split_beat(2, 32768));
        send_beat(split_beat(3, 65536));
        settle();
        write_reg(pps_pkg::CFG_SPLIT_COUNT, 4);
        write_reg(pps_pkg::CFG_SET_COUNT, 3);
        send_beat(phase_beat(8192));
        send_beat(phase_beat(16384));
        send_beat(phase_beat(40000));
        send_beat(phase_beat(65536));
        send_beat(phase_beat(PHASE_MAX));
        send_beat(phase_beat(100));
        send_beat(phase_beat(65536));
        settle();
    endtask

    task automatic test_count_shrink();
        write_reg(pps_pkg::CFG_SPLIT_COUNT, 2);
        write_reg(CFG_SPARE_A, 7);
        write_reg(CFG_SPARE_B, 31);
        send_beat(phase_beat(70000));
        settle();
    endtask

    task automatic test_unordered_table();
        send_beat(phase_beat(20000));
        send_beat(split_beat(0, 30000));
        send_beat(split_beat(1, 24000));
        send_beat(phase_beat(22000));
        send_beat(split_beat(1, 40000));
        send_beat(phase_beat(23000));
        settle();
        write_reg(pps_pkg::CFG_SET_COUNT, 31);
        send_beat(phase_beat(23500));
        settle();
    endtask

    task automatic play_group(input int cnt_val, input int set_val, input int beats);
        int v;
        int mode;
        int step_max;
        int ph;
        int pick;
        mode = $urandom_range(0, 3);
        v    = 0;
        for (int i = 0; i < pps_pkg::MAX_SPLITS; i++) begin
            if (mode == 3) begin
                v = $urandom_range(0, PHASE_MAX);
            end else begin
                v += $urandom_range(0, 1024 << mode);
                if (v > 65536) v = 65536;
            end
            send_beat(split_beat(i, v));
        end
        settle();
        write_reg(pps_pkg::CFG_SPLIT_COUNT, cnt_val);
        write_reg(pps_pkg::CFG_SET_COUNT, set_val);
        step_max = $urandom_range(64, 8192);
        ph       = $urandom_range(0, 2048);
        repeat (beats) begin
            pick = $urandom_range(0, 31);
            if (pick == 0) begin
                send_beat(split_beat($urandom_range(0, 15), $urandom_range(0, PHASE_MAX)));
            end else if (pick <= 2) begin
                send_beat(phase_beat($urandom_range(0, PHASE_MAX)));
            end else if (pick <= 4) begin
                send_beat(phase_beat(int'(split_shadow[$urandom_range(0, 15)])));
            end else begin
                if (ph >= 65536) begin
                    ph = $urandom_range(0, 2048);
                end else begin
                    ph += $urandom_range(0, step_max);
                    if (ph > 65536) ph = 65536;
                end
                send_beat(phase_beat(ph));
            end
        end
        settle();
    endtask

    task automatic test_random_settings();
        int cnt_pick [9];
        int set_pick [9];
        cnt_pick = '{16, 0, 31, 1, 8, 3, 12, 16, 2};
        set_pick = '{16, 0, 1, 31, 3, 5, 7, 2, 16};
        for (int g = 0; g < 9; g++) begin
            if (g == 5 || g == 6) begin
                cnt_pick[g] = $urandom_range(0, 31);
                set_pick[g] = $urandom_range(0, 31);
            end
            play_group(cnt_pick[g], set_pick[g], 100);
        end
    endtask

    task automatic test_backpressure();
        int ph;
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_on <= 1'b0;
            end
        join_none
        ph = 0;
        repeat (30) begin
            ph += $urandom_range(0, 2000);
            send_beat(phase_beat(ph));
        end
        settle();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        play_group(16, 16, 100);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_segment_walk();
        test_count_shrink();
        test_unordered_table();
        test_random_settings();
        test_backpressure();
        test_steady_stream();
        if (mismatch_cnt == 0) begin
            $display("piecewise_phase_segmenter_unit_tb OK");
        end else begin
            $display("piecewise_phase_segmenter_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
